// ----- hdl/tle_pkg.sv -----
// Shared types and constants for the terminal line editor.
// Holds the request/result payload structs, action codes and key codes.
// No dependencies.
package tle_pkg;

    // Default line storage depth; the line holds one character less than this.
    localparam int LINE_CAPACITY_DEF = 64;

    // Request commands.
    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Result actions.
    localparam logic [2:0] ACT_ECHO    = 3'd0;
    localparam logic [2:0] ACT_ERASE   = 3'd1;
    localparam logic [2:0] ACT_BEEP    = 3'd2;
    localparam logic [2:0] ACT_NEWLINE = 3'd3;
    localparam logic [2:0] ACT_INTR    = 3'd4;
    localparam logic [2:0] ACT_READ    = 3'd5;

    // Key codes with a special meaning.
    localparam logic [7:0] KEY_CTRL_C = 8'h03;
    localparam logic [7:0] KEY_BS     = 8'h08;
    localparam logic [7:0] KEY_TAB    = 8'h09;
    localparam logic [7:0] KEY_LF     = 8'h0A;
    localparam logic [7:0] KEY_CR     = 8'h0D;
    localparam logic [7:0] KEY_ESC    = 8'h1B;
    localparam logic [7:0] KEY_SPACE  = 8'h20;
    localparam logic [7:0] KEY_DEL    = 8'h7F;

    typedef struct packed {
        logic       command;
        logic [7:0] key_byte;
        logic [5:0] read_index;
    } req_item_t;

    typedef struct packed {
        logic [2:0] action;
        logic [6:0] out_char;
        logic [5:0] erase_count;
        logic [5:0] line_length;
    } res_item_t;

    // Outcome of decoding one key byte.
    typedef struct packed {
        logic       emit;
        logic [2:0] action;
        logic [6:0] out_char;
        logic [5:0] erase_count;
        logic       wr_en;
        logic       after_return;
    } dec_t;

endpackage

// ----- hdl/tle_decode.sv -----
// Key byte decoder for the terminal line editor.
// Purely combinational: maps a key byte and the line state to an edit outcome.
// Depends on tle_pkg.
module tle_decode #(
    parameter int LINE_CAPACITY = tle_pkg::LINE_CAPACITY_DEF
) (
    input  logic [7:0]                       key_byte,
    input  logic                             after_return,
    input  logic [$clog2(LINE_CAPACITY)-1:0] count,
    output tle_pkg::dec_t                    dec,
    output logic [$clog2(LINE_CAPACITY)-1:0] count_next
);

    localparam int CW   = $clog2(LINE_CAPACITY);
    localparam int CMPW = (CW > 6) ? CW : 6;
    localparam logic [CW-1:0] COUNT_FULL = CW'(LINE_CAPACITY - 1);

    logic [7:0]      key_c;
    logic [CMPW-1:0] count_ext;

    assign count_ext = CMPW'(count);

    always_comb
    begin
        dec              = '0;
        dec.after_return = 1'b0;
        count_next       = count;
        // A carriage return is handled as a line feed from here on.
        key_c = (key_byte == tle_pkg::KEY_CR) ? tle_pkg::KEY_LF : key_byte;

        priority if (after_return && key_byte == tle_pkg::KEY_LF)
        begin
            // The line feed of a CR LF pair is swallowed without a result.
            dec.emit = 1'b0;
        end
        else
        begin
            dec.emit         = 1'b1;
            dec.after_return = (key_byte == tle_pkg::KEY_CR);
            priority if (key_c == tle_pkg::KEY_CTRL_C)
            begin
                dec.action = tle_pkg::ACT_INTR;
                count_next = '0;
            end
            else if (key_c == tle_pkg::KEY_ESC)
            begin
                if (count == '0)
                begin
                    dec.action = tle_pkg::ACT_BEEP;
                end
                else
                begin
                    dec.action      = tle_pkg::ACT_ERASE;
                    dec.erase_count = count_ext[5:0];
                    count_next      = '0;
                end
            end
            else if (key_c == tle_pkg::KEY_BS || key_c == tle_pkg::KEY_DEL)
            begin
                if (count == '0)
                begin
                    dec.action = tle_pkg::ACT_BEEP;
                end
                else
                begin
                    dec.action      = tle_pkg::ACT_ERASE;
                    dec.erase_count = 6'd1;
                    count_next      = count - CW'(1);
                end
            end
            else if (key_c == tle_pkg::KEY_LF)
            begin
                dec.action   = tle_pkg::ACT_NEWLINE;
                dec.out_char = tle_pkg::KEY_LF[6:0];
            end
            else
            begin
                if (key_c == tle_pkg::KEY_TAB)
                begin
                    key_c = tle_pkg::KEY_SPACE;
                end
                if (key_c < tle_pkg::KEY_SPACE || key_c >= tle_pkg::KEY_DEL)
                begin
                    dec.action = tle_pkg::ACT_BEEP;
                end
                else if (count >= COUNT_FULL)
                begin
                    dec.action = tle_pkg::ACT_BEEP;
                end
                else
                begin
                    dec.action   = tle_pkg::ACT_ECHO;
                    dec.out_char = key_c[6:0];
                    dec.wr_en    = 1'b1;
                    count_next   = count + CW'(1);
                end
            end
        end
    end

endmodule

// ----- hdl/terminal_line_editor_top.sv -----
// Terminal line editor top level: edits a command line from key bytes.
// A result passes through the middle stage and then the result register on its way to res.
// Throughput: one request per cycle; the request side stalls only while the
// result register is full and stalled and the middle stage is occupied.
// Reset clears the line length, the CR flag and all valid flags at once; the
// line storage is not cleared and needs no clearing pass.
// Depends on tle_pkg and tle_decode.
module terminal_line_editor_top #(
    parameter int LINE_CAPACITY = tle_pkg::LINE_CAPACITY_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  tle_pkg::req_item_t req,
    output logic               res_valid,
    input  logic               res_stall,
    output tle_pkg::res_item_t res
);

    localparam int CW   = $clog2(LINE_CAPACITY);
    localparam int CMPW = (CW > 6) ? CW : 6;

    // Line length and the flag that marks a preceding carriage return. Both
    // change at the edge that accepts a key request, so the next request in
    // the following cycle already sees the updated line.
    logic [CW-1:0] count_reg, count_next;
    logic          ar_reg, ar_next;

    // Middle stage: the decoded result, waiting for the registered memory
    // read data when the request was a read.
    logic               s1_valid_reg, s1_valid_next;
    tle_pkg::res_item_t s1_item_reg, s1_item_next;
    logic               s1_is_read_reg, s1_is_read_next;
    logic               s1_in_range_reg, s1_in_range_next;

    // Result register.
    logic               res_valid_reg, res_valid_next;
    tle_pkg::res_item_t res_item_reg, res_item_next;

    // Line storage, written at the line end and read at the requested index.
    logic [6:0]    line_mem [LINE_CAPACITY];
    logic [6:0]    rdata_reg;
    logic [CW-1:0] rd_addr;

    logic            req_fire;
    logic            s1_move;
    logic            key_fire;
    logic [CMPW-1:0] idx_ext;
    logic [CMPW-1:0] count_ext;
    logic [CMPW-1:0] count_next_ext;

    tle_pkg::dec_t dec;
    logic [CW-1:0] dec_count_next;

    tle_decode #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_decode (
        .key_byte     (req.key_byte),
        .after_return (ar_reg),
        .count        (count_reg),
        .dec          (dec),
        .count_next   (dec_count_next)
    );

    // The middle stage moves on when the result register is empty or is
    // being emptied in this cycle; a request is taken when the middle stage
    // is empty or moving on.
    assign s1_move   = s1_valid_reg && (!res_valid_reg || !res_stall);
    assign req_stall = s1_valid_reg && !s1_move;
    assign req_fire  = req_valid && !req_stall;
    assign key_fire  = req_fire && (req.command == tle_pkg::CMD_KEY);

    assign idx_ext        = CMPW'(req.read_index);
    assign count_ext      = CMPW'(count_reg);
    assign count_next_ext = CMPW'(dec_count_next);
    assign rd_addr        = idx_ext[CW-1:0];

    always_comb
    begin
        count_next = count_reg;
        ar_next    = ar_reg;
        if (key_fire)
        begin
            count_next = dec_count_next;
            ar_next    = dec.after_return;
        end
    end

    always_comb
    begin
        s1_valid_next    = s1_valid_reg;
        s1_item_next     = s1_item_reg;
        s1_is_read_next  = s1_is_read_reg;
        s1_in_range_next = s1_in_range_reg;
        if (req_fire)
        begin
            if (req.command == tle_pkg::CMD_READ)
            begin
                // Indexes at or past the line end read as zero.
                s1_valid_next            = 1'b1;
                s1_is_read_next          = 1'b1;
                s1_in_range_next         = (idx_ext < count_ext);
                s1_item_next.action      = tle_pkg::ACT_READ;
                s1_item_next.out_char    = '0;
                s1_item_next.erase_count = '0;
                s1_item_next.line_length = count_ext[5:0];
            end
            else
            begin
                s1_valid_next            = dec.emit;
                s1_is_read_next          = 1'b0;
                s1_in_range_next         = 1'b0;
                s1_item_next.action      = dec.action;
                s1_item_next.out_char    = dec.out_char;
                s1_item_next.erase_count = dec.erase_count;
                s1_item_next.line_length = count_next_ext[5:0];
            end
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_item_next  = res_item_reg;
        if (s1_move)
        begin
            res_valid_next = 1'b1;
            res_item_next  = s1_item_reg;
            if (s1_is_read_reg)
            begin
                res_item_next.out_char = s1_in_range_reg ? rdata_reg : 7'd0;
            end
        end
        else if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ar_reg        <= 1'b0;
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ar_reg        <= ar_next;
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg     <= s1_item_next;
        s1_is_read_reg  <= s1_is_read_next;
        s1_in_range_reg <= s1_in_range_next;
        res_item_reg    <= res_item_next;
    end

    // The read data is captured only when a request is taken, so it holds
    // while the middle stage waits on a stalled result.
    always_ff @(posedge clk)
    begin
        if (key_fire && dec.wr_en)
        begin
            line_mem[count_reg] <= dec.out_char;
        end
        if (req_fire)
        begin
            rdata_reg <= line_mem[rd_addr];
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_item_reg;

`ifndef NO_ASSERTIONS
    // The middle stage never overwrites a result that is still stalled.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_stall) |-> !s1_move)
        else $error("middle stage moved into a stalled result register");

    // An erase result always erases at least one character.
    a_erase_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.action == tle_pkg::ACT_ERASE) |-> (res.erase_count != 6'd0))
        else $error("erase result with zero erase count");

    // A read past the line end delivers zero.
    a_read_past_end: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && s1_is_read_reg && !s1_in_range_reg) |=> (res.out_char == 7'd0))
        else $error("read past line end returned nonzero data");

    // A swallowed line feed leaves the line length unchanged.
    a_lf_swallow: assert property (@(posedge clk) disable iff (!rst_n)
        (key_fire && ar_reg && req.key_byte == tle_pkg::KEY_LF) |=>
            (count_reg == $past(count_reg) && !ar_reg))
        else $error("swallowed line feed changed the line state");
`endif

endmodule
